// ===== hw/rtl/mcva_pkg.sv =====
// Shared types and constants of the MIDI note to CV voice allocator.
package mcva_pkg;

  localparam int NOTE_SLOTS   = 16;
  localparam int SLOT_W       = $clog2(NOTE_SLOTS);
  localparam int CNT_W        = $clog2(NOTE_SLOTS + 1);
  localparam int CLOCK_DIVIDE = 24;
  localparam int PHASE_W      = $clog2(CLOCK_DIVIDE);
  localparam int GAIN_W       = 24;
  localparam int CODE_W       = 12;
  localparam int PROD_W       = 31;
  localparam int ENTRY_W      = 14;

  localparam logic [2:0] FN_NOTE_ON  = 3'd0;
  localparam logic [2:0] FN_NOTE_OFF = 3'd1;
  localparam logic [2:0] FN_CLOCK    = 3'd2;
  localparam logic [2:0] FN_START    = 3'd3;
  localparam logic [2:0] FN_LEARN    = 3'd4;

  localparam logic [1:0] CFG_VOICE_MODE = 2'd0;
  localparam logic [1:0] CFG_PITCH_GAIN = 2'd1;
  localparam logic [1:0] CFG_PITCH2_GAIN = 2'd2;
  localparam logic [1:0] CFG_VEL_GAIN   = 2'd3;

  localparam logic [3:0] DRUM_CHANNEL = 4'd9;
  localparam logic [4:0] ALL_CHANNELS = 5'd16;
  localparam logic [6:0] LOW_NOTE     = 7'd24;
  localparam logic [6:0] HIGH_NOTE    = 7'd96;
  localparam logic [6:0] DRUM_FIRST   = 7'd36;
  localparam logic [6:0] DRUM_LAST    = 7'd39;
  localparam logic [CODE_W-1:0] CODE_MAX = 12'd4095;

  localparam logic [GAIN_W-1:0] PITCH_GAIN_RST = 24'd2236416;
  localparam logic [GAIN_W-1:0] VEL_GAIN_RST   = 24'd1056574;

  typedef struct packed {
    logic [2:0] func;
    logic [3:0] channel;
    logic [6:0] note_number;
    logic [6:0] velocity;
  } in_word_t;

  typedef struct packed {
    logic [11:0] cv1_code;
    logic [11:0] cv2_code;
    logic        gate;
    logic        trigger;
    logic        trigger_fire;
    logic        clock_out;
    logic        start_out;
    logic        start_fire;
    logic [3:0]  drum_gates;
    logic        learning;
  } out_word_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_EVENT, OP_PUSH_RD, OP_PUSH_WR, OP_PUSH_TOP,
    OP_REM_RD, OP_REM_WR, OP_POST, OP_FIND_RD, OP_FIND_CHK,
    OP_MUL_GO, OP_MUL_ST, OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic ev_on;
    logic ev_off;
    logic push_empty;
    logic push_last;
    logic rem_empty;
    logic rem_last;
    logic post_find;
    logic find_done;
    logic mul_pend;
  } dp_stat_t;

endpackage

// ===== hw/rtl/mcva_ctrl.sv =====
// Sequencer for the voice allocator: walks each word through its steps.
module mcva_ctrl import mcva_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     in_stall,
  output logic     out_valid
);

  typedef enum logic [3:0] {
    S_IDLE, S_EVENT, S_PUSH_RD, S_PUSH_WR, S_PUSH_TOP, S_REM_RD, S_REM_WR,
    S_POST, S_FIND_RD, S_FIND_CHK, S_MUL_GO, S_MUL_ST, S_FIN
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.op = OP_NONE;
    unique case (state_r)
      S_IDLE:     cmd.op = in_valid ? OP_LOAD : OP_NONE;
      S_EVENT:    cmd.op = OP_EVENT;
      S_PUSH_RD:  cmd.op = OP_PUSH_RD;
      S_PUSH_WR:  cmd.op = OP_PUSH_WR;
      S_PUSH_TOP: cmd.op = OP_PUSH_TOP;
      S_REM_RD:   cmd.op = OP_REM_RD;
      S_REM_WR:   cmd.op = OP_REM_WR;
      S_POST:     cmd.op = OP_POST;
      S_FIND_RD:  cmd.op = OP_FIND_RD;
      S_FIND_CHK: cmd.op = OP_FIND_CHK;
      S_MUL_GO:   cmd.op = stat.mul_pend ? OP_MUL_GO : OP_NONE;
      S_MUL_ST:   cmd.op = OP_MUL_ST;
      S_FIN:      cmd.op = out_free ? OP_OUT : OP_NONE;
      default:    cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // load a new result word, or drop the old one once taken
      if (state_r == S_FIN && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_valid) state_r <= S_EVENT;
        S_EVENT: begin
          priority if (stat.ev_on)
            state_r <= stat.push_empty ? S_PUSH_TOP : S_PUSH_RD;
          else if (stat.ev_off)
            state_r <= stat.rem_empty ? S_POST : S_REM_RD;
          else
            state_r <= S_MUL_GO;
        end
        S_PUSH_RD:  state_r <= S_PUSH_WR;
        S_PUSH_WR:  state_r <= stat.push_last ? S_PUSH_TOP : S_PUSH_RD;
        S_PUSH_TOP: state_r <= S_MUL_GO;
        S_REM_RD:   state_r <= S_REM_WR;
        S_REM_WR:   state_r <= stat.rem_last ? S_POST : S_REM_RD;
        S_POST:     state_r <= stat.post_find ? S_FIND_RD : S_MUL_GO;
        S_FIND_RD:  state_r <= S_FIND_CHK;
        S_FIND_CHK: state_r <= stat.find_done ? S_MUL_GO : S_FIND_RD;
        S_MUL_GO:   state_r <= stat.mul_pend ? S_MUL_ST : S_FIN;
        S_MUL_ST:   state_r <= S_MUL_GO;
        S_FIN: begin
          if (out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/mcva_dp.sv =====
// Datapath: event decode, held-note memory, voice state, scaling and result word.
module mcva_dp import mcva_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  input  in_word_t          in_word,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [GAIN_W-1:0] cfg_data,
  output dp_stat_t          stat,
  output out_word_t         out_word
);

  typedef enum logic [1:0] {FS_MONO, FS_V1, FS_V2} fsel_t;

  logic [ENTRY_W-1:0] mem [NOTE_SLOTS];
  logic [ENTRY_W-1:0] rd_data_r;
  logic [SLOT_W-1:0]  rd_addr;
  logic               mem_we;
  logic [SLOT_W-1:0]  mem_wa;
  logic [ENTRY_W-1:0] mem_wd;

  in_word_t           item_r;
  out_word_t          out_r;
  logic               mode_r;
  logic [GAIN_W-1:0]  gain1_r, gain2_r, vgain_r;
  logic [CNT_W-1:0]   count_r, keep_r, ridx_r, widx_r, fidx_r;
  logic [SLOT_W-1:0]  idx_r;
  logic [6:0]         v1_r, v2_r, op_note_r, op_vel_r;
  logic               nextv_r, armed_r;
  logic [PHASE_W-1:0] phase_r;
  logic [4:0]         listen_r;
  logic [CODE_W-1:0]  cv1_r, cv2_r;
  logic               gate_r, trig_r, clock_r, start_r, tfire_r, sfire_r;
  logic [3:0]         drums_r;
  logic [2:0]         pend_r;
  fsel_t              fsel_r;
  logic [PROD_W-1:0]  prod_r;

  logic               is_note, is_off, drum_hit, chan_ok, ev_go, ev_on, ev_off, in_range;
  logic [4:0]         listen_eff;
  logic [CNT_W-1:0]   keep;
  logic               hit1, hit2;
  logic [6:0]         rd_note, other;
  logic               rem_keep, find_hit, find_end;
  logic [6:0]         steps, mul_note;
  logic [GAIN_W-1:0]  gain;
  logic [CODE_W-1:0]  code;
  logic [1:0]         drum_bit;

  assign is_note  = (item_r.func == FN_NOTE_ON) || (item_r.func == FN_NOTE_OFF);
  assign is_off   = (item_r.func == FN_NOTE_OFF) ||
                    (item_r.func == FN_NOTE_ON && item_r.velocity == 7'd0);
  assign drum_hit = (item_r.channel == DRUM_CHANNEL) && is_note &&
                    (item_r.note_number >= DRUM_FIRST) && (item_r.note_number <= DRUM_LAST);
  assign drum_bit = 2'(item_r.note_number - DRUM_FIRST);
  assign listen_eff = armed_r ? {1'b0, item_r.channel} : listen_r;
  assign chan_ok  = (listen_eff == ALL_CHANNELS) || (listen_eff == {1'b0, item_r.channel});
  assign ev_go    = is_note && !drum_hit && chan_ok;
  assign in_range = (item_r.note_number >= LOW_NOTE) && (item_r.note_number <= HIGH_NOTE);
  assign ev_on    = ev_go && !is_off && in_range;
  assign ev_off   = ev_go && is_off;
  assign keep     = (count_r < CNT_W'(NOTE_SLOTS)) ? count_r : CNT_W'(NOTE_SLOTS - 1);

  assign hit1 = (v1_r != 7'd0) && (v1_r == item_r.note_number);
  assign hit2 = !hit1 && (v2_r != 7'd0) && (v2_r == item_r.note_number);

  assign rd_note  = rd_data_r[6:0];
  always_comb begin
    unique case (fsel_r)
      FS_V1:   other = v2_r;
      FS_V2:   other = v1_r;
      default: other = 7'd0;
    endcase
  end
  assign rem_keep = (rd_note != item_r.note_number);
  assign find_hit = (rd_note != other);
  assign find_end = (fidx_r + CNT_W'(1) == count_r);

  assign stat.ev_on      = ev_on;
  assign stat.ev_off     = ev_off;
  assign stat.push_empty = (keep == '0);
  assign stat.push_last  = (idx_r == '0);
  assign stat.rem_empty  = (count_r == '0);
  assign stat.rem_last   = (ridx_r + CNT_W'(1) == count_r);
  assign stat.post_find  = (count_r != '0) && (!mode_r || hit1 || hit2);
  assign stat.find_done  = find_hit || find_end;
  assign stat.mul_pend   = (pend_r != 3'b000);

  // Pick the lowest pending scaling job: voice one pitch, velocity, voice two pitch.
  assign mul_note = (op_note_r >= LOW_NOTE) ? 7'(op_note_r - LOW_NOTE) : 7'd0;
  always_comb begin
    priority if (pend_r[0]) begin
      steps = mul_note;
      gain  = gain1_r;
    end else if (pend_r[1]) begin
      steps = op_vel_r;
      gain  = vgain_r;
    end else begin
      steps = mul_note;
      gain  = gain2_r;
    end
  end
  assign code = (prod_r[PROD_W-1:28] != '0) ? CODE_MAX : prod_r[27:16];

  always_comb begin
    unique case (cmd.op)
      OP_PUSH_RD: rd_addr = idx_r;
      OP_REM_RD:  rd_addr = ridx_r[SLOT_W-1:0];
      OP_FIND_RD: rd_addr = fidx_r[SLOT_W-1:0];
      default:    rd_addr = '0;
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = rd_data_r;
    unique case (cmd.op)
      OP_PUSH_WR: begin
        mem_we = 1'b1;
        mem_wa = idx_r + SLOT_W'(1);
      end
      OP_PUSH_TOP: begin
        mem_we = 1'b1;
        mem_wd = {item_r.velocity, item_r.note_number};
      end
      OP_REM_WR: begin
        mem_we = rem_keep;
        mem_wa = widx_r[SLOT_W-1:0];
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      gain1_r  <= PITCH_GAIN_RST;
      gain2_r  <= PITCH_GAIN_RST;
      vgain_r  <= VEL_GAIN_RST;
      count_r  <= '0;
      v1_r     <= '0;
      v2_r     <= '0;
      nextv_r  <= 1'b0;
      phase_r  <= '0;
      armed_r  <= 1'b0;
      listen_r <= ALL_CHANNELS;
      cv1_r    <= '0;
      cv2_r    <= '0;
      gate_r   <= 1'b0;
      trig_r   <= 1'b0;
      clock_r  <= 1'b0;
      start_r  <= 1'b0;
      drums_r  <= '0;
      tfire_r  <= 1'b0;
      sfire_r  <= 1'b0;
      pend_r   <= '0;
      fsel_r   <= FS_MONO;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_VOICE_MODE:  mode_r  <= cfg_data[0];
          CFG_PITCH_GAIN:  gain1_r <= cfg_data;
          CFG_PITCH2_GAIN: gain2_r <= cfg_data;
          CFG_VEL_GAIN:    vgain_r <= cfg_data;
          default:         mode_r  <= mode_r;
        endcase
      end
      unique case (cmd.op)
        OP_LOAD: begin
          item_r  <= in_word;
          tfire_r <= 1'b0;
          sfire_r <= 1'b0;
        end
        OP_EVENT: begin
          op_note_r <= item_r.note_number;
          op_vel_r  <= item_r.velocity;
          keep_r    <= keep;
          idx_r     <= SLOT_W'(keep - CNT_W'(1));
          ridx_r    <= '0;
          widx_r    <= '0;
          priority if (item_r.func == FN_START) begin
            start_r <= 1'b1;
            sfire_r <= 1'b1;
          end else if (item_r.func == FN_CLOCK) begin
            if (phase_r == '0) clock_r <= 1'b1;
            else if (phase_r == PHASE_W'(CLOCK_DIVIDE / 2)) clock_r <= 1'b0;
            phase_r <= (phase_r == PHASE_W'(CLOCK_DIVIDE - 1)) ? '0 : phase_r + PHASE_W'(1);
          end else if (item_r.func == FN_LEARN) begin
            if (armed_r) begin
              armed_r <= 1'b0;
              start_r <= 1'b0;
            end else begin
              armed_r <= 1'b1;
              count_r <= '0;
              cv1_r   <= '0;
              cv2_r   <= '0;
              gate_r  <= 1'b0;
              trig_r  <= 1'b0;
              clock_r <= 1'b0;
              start_r <= 1'b1;
            end
          end else if (drum_hit) begin
            drums_r[drum_bit] <= !is_off;
          end else begin
            if (armed_r) begin
              armed_r  <= 1'b0;
              listen_r <= {1'b0, item_r.channel};
              start_r  <= 1'b0;
            end
            if (ev_on) begin
              priority if (!mode_r) begin
                trig_r  <= 1'b1;
                tfire_r <= 1'b1;
                gate_r  <= 1'b1;
                pend_r  <= 3'b011;
              end else if (!nextv_r) begin
                v1_r    <= item_r.note_number;
                nextv_r <= 1'b1;
                gate_r  <= 1'b1;
                pend_r  <= 3'b001;
              end else begin
                v2_r    <= item_r.note_number;
                nextv_r <= 1'b0;
                trig_r  <= 1'b1;
                pend_r  <= 3'b100;
              end
            end
          end
        end
        OP_PUSH_WR: idx_r <= idx_r - SLOT_W'(1);
        OP_PUSH_TOP: count_r <= keep_r + CNT_W'(1);
        OP_REM_WR: begin
          ridx_r <= ridx_r + CNT_W'(1);
          if (rem_keep) widx_r <= widx_r + CNT_W'(1);
          if (ridx_r + CNT_W'(1) == count_r)
            count_r <= rem_keep ? widx_r + CNT_W'(1) : widx_r;
        end
        OP_POST: begin
          fidx_r <= '0;
          priority if (!mode_r) begin
            fsel_r <= FS_MONO;
            if (count_r == '0) gate_r <= 1'b0;
          end else if (hit1) begin
            fsel_r <= FS_V1;
            if (count_r == '0) begin
              gate_r <= 1'b0;
              v1_r   <= '0;
            end else begin
              nextv_r <= 1'b0;
            end
          end else if (hit2) begin
            fsel_r <= FS_V2;
            if (count_r == '0) begin
              trig_r <= 1'b0;
              v2_r   <= '0;
            end else begin
              nextv_r <= 1'b1;
            end
          end else begin
            fsel_r <= FS_MONO;
          end
        end
        OP_FIND_CHK: begin
          fidx_r <= fidx_r + CNT_W'(1);
          if (find_hit) begin
            op_note_r <= rd_note;
            op_vel_r  <= rd_data_r[13:7];
            unique case (fsel_r)
              FS_V1: begin
                v1_r   <= rd_note;
                pend_r <= 3'b001;
              end
              FS_V2: begin
                v2_r   <= rd_note;
                pend_r <= 3'b100;
              end
              default: pend_r <= 3'b011;
            endcase
          end else if (find_end) begin
            // no other note held: free the voice
            if (fsel_r == FS_V2) begin
              trig_r <= 1'b0;
              v2_r   <= '0;
            end else begin
              gate_r <= 1'b0;
              v1_r   <= '0;
            end
          end
        end
        OP_MUL_GO: prod_r <= PROD_W'(steps) * PROD_W'(gain);
        OP_MUL_ST: begin
          priority if (pend_r[0]) begin
            cv1_r     <= code;
            pend_r[0] <= 1'b0;
          end else if (pend_r[1]) begin
            cv2_r     <= code;
            pend_r[1] <= 1'b0;
          end else begin
            cv2_r     <= code;
            pend_r[2] <= 1'b0;
          end
        end
        OP_OUT: begin
          out_r.cv1_code     <= cv1_r;
          out_r.cv2_code     <= cv2_r;
          out_r.gate         <= gate_r;
          out_r.trigger      <= trig_r;
          out_r.trigger_fire <= tfire_r;
          out_r.clock_out    <= clock_r;
          out_r.start_out    <= start_r;
          out_r.start_fire   <= sfire_r;
          out_r.drum_gates   <= drums_r;
          out_r.learning     <= armed_r;
        end
        default: pend_r <= pend_r;
      endcase
    end
  end

  assign out_word = out_r;

endmodule

// ===== hw/rtl/midi_note_to_cv_voice_allocator_top.sv =====
// Top level of the MIDI note to CV voice allocator.
// One word is taken at a time and gives exactly one result word. Clock,
// start, learn, drum and ignored events skip the held-note memory and the
// multiplier. A note on shifts the held entries (at most 15) by one slot
// and writes the new note on top; a note off scans the held entries (at
// most 16) to remove the note and may search the remaining entries to
// refill a voice. Then 0 to 2 DAC codes are recomputed. The walk over the
// held-note memory takes each entry with a read step and then a write or
// check step; each code passes through the one 7x24 multiplier and is then
// stored. The next word is accepted in the cycle after the result is
// registered, and the input side is ready again while a finished result
// still waits on the output register.
module midi_note_to_cv_voice_allocator_top import mcva_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_word_t          in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output out_word_t         out_word,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [GAIN_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mcva_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  mcva_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .out_word  (out_word)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("block took a word but did not go busy");

  a_fires_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_word.trigger_fire && out_word.start_fire))
    else $error("trigger and start pulses in one result");

  a_start_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.start_fire |-> out_word.start_out)
    else $error("start pulse without start level");

endmodule

// ===== tb/midi_note_to_cv_voice_allocator_top_test.sv =====
// Self-checking testbench for the MIDI note to CV voice allocator top level.
`timescale 1ns / 1ps

module midi_note_to_cv_voice_allocator_top_test;
  import mcva_pkg::*;

  localparam logic [2:0] FN_OTHER  = 3'd5;
  localparam logic [2:0] FN_SPARE6 = 3'd6;
  localparam logic [2:0] FN_SPARE7 = 3'd7;
  localparam logic [GAIN_W-1:0] GAIN_FULL = 24'hFFFFFF;
  localparam int PHASES = 6;
  localparam int PHASE_WORDS = 255;
  localparam int SETTLE_CYCLES = 120;

  class cv_scoreboard;
    logic [ENTRY_W-1:0] stack [NOTE_SLOTS];
    int held;
    logic [6:0] voice1, voice2;
    bit next_is_two;
    int phase;
    bit armed;
    logic [4:0] listen;
    bit poly;
    logic [GAIN_W-1:0] gain1, gain2, vgain;
    out_word_t lv;
    out_word_t expected_q[$];
    bit failed;

    function new();
      held = 0; voice1 = 0; voice2 = 0; next_is_two = 0; phase = 0;
      armed = 0; listen = ALL_CHANNELS; poly = 0;
      gain1 = PITCH_GAIN_RST; gain2 = PITCH_GAIN_RST; vgain = VEL_GAIN_RST;
      lv = '0; failed = 0;
    endfunction

    function void configure(logic [1:0] idx, logic [GAIN_W-1:0] data);
      case (idx)
        CFG_VOICE_MODE:  poly = data[0];
        CFG_PITCH_GAIN:  gain1 = data;
        CFG_PITCH2_GAIN: gain2 = data;
        CFG_VEL_GAIN:    vgain = data;
        default: ;
      endcase
    endfunction

    function logic [11:0] scale(logic [6:0] steps, logic [GAIN_W-1:0] g);
      logic [PROD_W-1:0] p;
      p = {24'd0, steps} * {7'd0, g};
      return (p[30:16] > 15'd4095) ? CODE_MAX : p[27:16];
    endfunction

    function logic [11:0] pitch(logic [6:0] n, logic [GAIN_W-1:0] g);
      return scale((n >= LOW_NOTE) ? n - LOW_NOTE : 7'd0, g);
    endfunction

    // newest entry whose note differs from other, or held when none
    function int find_other(logic [6:0] other);
      for (int i = 0; i < held; i++)
        if (stack[i][6:0] != other) return i;
      return held;
    endfunction

    function void play_on(logic [6:0] n, logic [6:0] v);
      int keep;
      if (n < LOW_NOTE || n > HIGH_NOTE) return;
      if (!poly) begin
        lv.cv1_code = pitch(n, gain1);
        lv.cv2_code = scale(v, vgain);
        lv.trigger = 1; lv.trigger_fire = 1; lv.gate = 1;
      end else if (!next_is_two) begin
        voice1 = n; next_is_two = 1;
        lv.cv1_code = pitch(n, gain1); lv.gate = 1;
      end else begin
        voice2 = n; next_is_two = 0;
        lv.cv2_code = pitch(n, gain2); lv.trigger = 1;
      end
      // drop the oldest when full
      keep = (held < NOTE_SLOTS) ? held : NOTE_SLOTS - 1;
      for (int i = keep; i > 0; i--) stack[i] = stack[i-1];
      stack[0] = {v, n};
      held = keep + 1;
    endfunction

    function void play_off(logic [6:0] n);
      int w, i;
      w = 0;
      for (int r = 0; r < held; r++)
        if (stack[r][6:0] != n) begin
          stack[w] = stack[r]; w++;
        end
      held = w;
      if (!poly) begin
        if (held == 0) lv.gate = 0;
        else begin
          lv.cv1_code = pitch(stack[0][6:0], gain1);
          lv.cv2_code = scale(stack[0][13:7], vgain);
        end
      end else if (voice1 != 0 && voice1 == n) begin
        if (held == 0) begin
          lv.gate = 0; voice1 = 0;
        end else begin
          i = find_other(voice2);
          if (i < held) begin
            voice1 = stack[i][6:0]; lv.cv1_code = pitch(voice1, gain1);
          end else begin
            lv.gate = 0; voice1 = 0;
          end
          next_is_two = 0;
        end
      end else if (voice2 != 0 && voice2 == n) begin
        if (held == 0) begin
          lv.trigger = 0; voice2 = 0;
        end else begin
          i = find_other(voice1);
          if (i < held) begin
            voice2 = stack[i][6:0]; lv.cv2_code = pitch(voice2, gain2);
          end else begin
            lv.trigger = 0; voice2 = 0;
          end
          next_is_two = 1;
        end
      end
    endfunction

    function void note_input(in_word_t w);
      bit done, is_off;
      lv.trigger_fire = 0; lv.start_fire = 0;
      if (w.func == FN_START) begin
        lv.start_out = 1; lv.start_fire = 1;
      end else if (w.func == FN_CLOCK) begin
        if (phase == 0) lv.clock_out = 1;
        else if (phase == CLOCK_DIVIDE / 2) lv.clock_out = 0;
        phase++;
        if (phase >= CLOCK_DIVIDE) phase = 0;
      end else if (w.func == FN_LEARN) begin
        if (armed) begin
          armed = 0; lv.start_out = 0;
        end else begin
          armed = 1; held = 0;
          lv.cv1_code = 0; lv.cv2_code = 0;
          lv.gate = 0; lv.trigger = 0; lv.clock_out = 0; lv.start_out = 1;
        end
      end else begin
        done = 0;
        is_off = (w.func == FN_NOTE_OFF) || (w.func == FN_NOTE_ON && w.velocity == 0);
        if (w.channel == DRUM_CHANNEL && w.func <= FN_NOTE_OFF &&
            w.note_number >= DRUM_FIRST && w.note_number <= DRUM_LAST) begin
          lv.drum_gates[w.note_number - DRUM_FIRST] = !is_off;
          done = 1;
        end
        if (!done) begin
          if (armed) begin
            armed = 0; listen = {1'b0, w.channel}; lv.start_out = 0;
          end
          if ((listen == ALL_CHANNELS || {1'b0, w.channel} == listen) &&
              w.func <= FN_NOTE_OFF) begin
            if (is_off) play_off(w.note_number);
            else play_on(w.note_number, w.velocity);
          end
        end
      end
      lv.learning = armed;
      expected_q.push_back(lv);
    endfunction

    function void field(string name, int exp_v, int got_v);
      if (exp_v != got_v) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
        failed = 1;
      end
    endfunction

    function void check(out_word_t got);
      out_word_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got);
        failed = 1;
        return;
      end
      e = expected_q.pop_front();
      field("cv1_code", e.cv1_code, got.cv1_code);
      field("cv2_code", e.cv2_code, got.cv2_code);
      field("gate", e.gate, got.gate);
      field("trigger", e.trigger, got.trigger);
      field("trigger_fire", e.trigger_fire, got.trigger_fire);
      field("clock_out", e.clock_out, got.clock_out);
      field("start_out", e.start_out, got.start_out);
      field("start_fire", e.start_fire, got.start_fire);
      field("drum_gates", e.drum_gates, got.drum_gates);
      field("learning", e.learning, got.learning);
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, cfg_we;
  in_word_t in_word;
  out_word_t out_word;
  logic [1:0] cfg_index;
  logic [GAIN_W-1:0] cfg_data;

  cv_scoreboard sb = new();
  int burst_left;
  int stall_mode, stall_left;

  midi_note_to_cv_voice_allocator_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0; rst_n = 0; in_valid = 0; in_word = '0;
    out_stall = 0; cfg_we = 0; cfg_index = CFG_VOICE_MODE; cfg_data = '0;
  end

  always #5 clk = ~clk;

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // receiver: stall on its own changing pattern, with clean stretches
  always @(posedge clk) begin
    if (stall_left <= 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(40, 300);
      out_stall <= 0;
    end else begin
      stall_left <= stall_left - 1;
      case (stall_mode)
        0: out_stall <= 0;
        1: out_stall <= ($urandom_range(0, 99) < 35);
        default: out_stall <= (stall_left % 16) >= 10;
      endcase
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && !out_stall) sb.check(out_word);

  task automatic write_reg(logic [1:0] idx, logic [GAIN_W-1:0] data);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= data;
    @(posedge clk);
    cfg_we <= 0;
    sb.configure(idx, data);
    @(posedge clk);
  endtask

  task automatic send(in_word_t w);
    int gap;
    in_valid <= 1; in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(w);
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 30);
      gap = $urandom_range(0, 25);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic event_word(logic [2:0] f, logic [3:0] ch, logic [6:0] n, logic [6:0] v);
    in_word_t w;
    w.func = f; w.channel = ch; w.note_number = n; w.velocity = v;
    send(w);
  endtask

  task automatic drain();
    // drop valid first so the last word is not taken again
    in_valid <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic in_word_t random_word();
    in_word_t w;
    int r;
    r = $urandom_range(0, 99);
    w.channel = (sb.listen == ALL_CHANNELS || $urandom_range(0, 9) == 0) ?
                4'($urandom_range(0, 15)) : sb.listen[3:0];
    w.note_number = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                                : 7'($urandom_range(24, 44));
    w.velocity = ($urandom_range(0, 49) == 0) ? 7'd0 : 7'($urandom_range(1, 127));
    if (r < 45) w.func = FN_NOTE_ON;
    else if (r < 78) w.func = FN_NOTE_OFF;
    else if (r < 88) w.func = FN_CLOCK;
    else if (r < 90) w.func = FN_START;
    else if (r < 93) w.func = FN_LEARN;
    else w.func = 3'($urandom_range(FN_OTHER, FN_SPARE7));
    return w;
  endfunction

  initial begin
    logic [GAIN_W-1:0] g1, g2, gv;
    burst_left = 0; stall_left = 0; stall_mode = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    write_reg(CFG_VOICE_MODE, 0);
    write_reg(CFG_PITCH_GAIN, PITCH_GAIN_RST);
    write_reg(CFG_PITCH2_GAIN, PITCH_GAIN_RST);
    write_reg(CFG_VEL_GAIN, VEL_GAIN_RST);

    // directed: range edges, drums, timing, learn and capture
    event_word(FN_NOTE_ON, 0, 24, 127);
    event_word(FN_NOTE_ON, 0, 96, 1);
    event_word(FN_NOTE_ON, 0, 23, 64);
    event_word(FN_NOTE_ON, 0, 97, 64);
    event_word(FN_NOTE_ON, 0, 127, 0);
    event_word(FN_NOTE_OFF, 0, 96, 5);
    event_word(FN_NOTE_OFF, 0, 24, 0);
    event_word(FN_NOTE_ON, DRUM_CHANNEL, 36, 100);
    event_word(FN_NOTE_ON, DRUM_CHANNEL, 37, 100);
    event_word(FN_NOTE_ON, DRUM_CHANNEL, 38, 100);
    event_word(FN_NOTE_ON, DRUM_CHANNEL, 39, 100);
    event_word(FN_NOTE_ON, DRUM_CHANNEL, 0, 0);
    event_word(FN_NOTE_OFF, DRUM_CHANNEL, 37, 0);
    event_word(FN_CLOCK, 0, 0, 0);
    event_word(FN_START, 15, 127, 127);
    event_word(FN_OTHER, 15, 60, 60);
    event_word(FN_SPARE6, 2, 60, 60);
    event_word(FN_SPARE7, 2, 60, 60);
    event_word(FN_LEARN, 0, 0, 0);
    event_word(FN_LEARN, 0, 0, 0);
    event_word(FN_LEARN, 0, 0, 0);
    event_word(FN_NOTE_ON, 3, 60, 80);
    event_word(FN_NOTE_ON, 4, 61, 80);
    event_word(FN_NOTE_OFF, 3, 60, 0);

    for (int p = 0; p < PHASES; p++) begin
      // pause the sender until every result is back, then retune
      drain();
      case (p)
        0: begin g1 = PITCH_GAIN_RST; g2 = PITCH_GAIN_RST; gv = VEL_GAIN_RST; end
        1: begin g1 = 0; g2 = 0; gv = 0; end
        2: begin g1 = GAIN_FULL; g2 = GAIN_FULL; gv = GAIN_FULL; end
        default: begin
          g1 = GAIN_W'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 8));
          g2 = GAIN_W'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 8));
          gv = GAIN_W'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 8));
        end
      endcase
      write_reg(CFG_VOICE_MODE, GAIN_W'(p % 2));
      write_reg(CFG_PITCH_GAIN, g1);
      write_reg(CFG_PITCH2_GAIN, g2);
      write_reg(CFG_VEL_GAIN, gv);
      for (int i = 0; i < PHASE_WORDS; i++) send(random_word());
    end

    drain();
    if (!sb.failed && sb.expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/mcva_pkg.sv
hw/rtl/mcva_ctrl.sv
hw/rtl/mcva_dp.sv
hw/rtl/midi_note_to_cv_voice_allocator_top.sv
tb/midi_note_to_cv_voice_allocator_top_test.sv
